### rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// Sprite pixel collision package
// Shared types, codes and fixed field widths of the sprite collision block.
// ----------------------------------------------------------------------------
package spc_pkg;

  localparam int unsigned CoordBits   = 12;
  localparam int unsigned CalcBits    = CoordBits + 2;
  localparam int unsigned SizeBits    = 7;
  localparam int unsigned RowBits     = 64;
  localparam int unsigned RowIdxBits  = 6;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned RowAddrBits = 8;
  localparam int unsigned RowCntBits  = 9;
  localparam int unsigned ColBits     = 7;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_TEST   = 2'd2
  } op_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_WIDTH_A  = 2'd0,
    REG_HEIGHT_A = 2'd1,
    REG_WIDTH_B  = 2'd2,
    REG_HEIGHT_B = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOX,
    ST_PLAN,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]                  op;
    logic [RowIdxBits-1:0]       row_index;
    logic [RowBits-1:0]          row_bits;
    logic signed [CoordBits-1:0] pos_ax;
    logic signed [CoordBits-1:0] pos_ay;
    logic signed [CoordBits-1:0] pos_bx;
    logic signed [CoordBits-1:0] pos_by;
  } in_t;

  typedef struct packed {
    logic hit;
    logic boxes_meet;
  } out_t;

  typedef struct packed {
    logic [SizeBits-1:0] width_a;
    logic [SizeBits-1:0] height_a;
    logic [SizeBits-1:0] width_b;
    logic [SizeBits-1:0] height_b;
  } sizes_t;

  // Result of the box test: where the overlap starts in each mask and how big it is.
  typedef struct packed {
    logic                   go;
    logic                   boxes_meet;
    logic [RowAddrBits-1:0] a_row0;
    logic [RowAddrBits-1:0] b_row0;
    logic [RowCntBits-1:0]  rows;
    logic [ColBits-1:0]     a_shift;
    logic [ColBits-1:0]     b_shift;
    logic [ColBits-1:0]     cols;
  } plan_t;

endpackage

### rtl/spc_mask_mem.sv
// ----------------------------------------------------------------------------
// Sprite mask memory
// One opacity mask, one row per entry, one write and one registered read port.
// ----------------------------------------------------------------------------
module spc_mask_mem #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### rtl/spc_box.sv
// ----------------------------------------------------------------------------
// Sprite box test
// Two-stage bounding-box rejection test and overlap rectangle setup.
// ----------------------------------------------------------------------------
module spc_box #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic           clk_i,
  input  logic           capture_i,
  input  spc_pkg::in_t    item_i,
  input  spc_pkg::sizes_t sizes_i,
  output spc_pkg::plan_t  plan_o
);

  localparam int unsigned CW  = spc_pkg::CalcBits;
  localparam int unsigned Ext = spc_pkg::CalcBits - spc_pkg::CoordBits;

  logic [spc_pkg::SizeBits-1:0] wa, ha, wb, hb;
  logic [8:0] ha_ext, hb_ext;

  logic signed [CW-1:0] ax_d, ay_d, bx_d, by_d;
  logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;
  logic signed [CW-1:0] axe_q, aye_q, bxe_q, bye_q;
  logic signed [CW-1:0] wa_q, ha_q, wb_q, hb_q;

  logic signed [CW-1:0] rows_c, cols_c;
  logic                 reject, a_top, a_bot, a_left, a_right;
  spc_pkg::plan_t       plan_d, plan_q;

  // Sizes above the storage limits are taken at the limit.
  assign ha_ext = {2'b00, sizes_i.height_a};
  assign hb_ext = {2'b00, sizes_i.height_b};
  assign wa = (sizes_i.width_a > spc_pkg::SizeBits'(MAX_WIDTH)) ?
              spc_pkg::SizeBits'(MAX_WIDTH) : sizes_i.width_a;
  assign wb = (sizes_i.width_b > spc_pkg::SizeBits'(MAX_WIDTH)) ?
              spc_pkg::SizeBits'(MAX_WIDTH) : sizes_i.width_b;
  assign ha = (ha_ext > 9'(MAX_HEIGHT)) ? spc_pkg::SizeBits'(MAX_HEIGHT) : sizes_i.height_a;
  assign hb = (hb_ext > 9'(MAX_HEIGHT)) ? spc_pkg::SizeBits'(MAX_HEIGHT) : sizes_i.height_b;

  assign ax_d = {{Ext{item_i.pos_ax[spc_pkg::CoordBits-1]}}, item_i.pos_ax};
  assign ay_d = {{Ext{item_i.pos_ay[spc_pkg::CoordBits-1]}}, item_i.pos_ay};
  assign bx_d = {{Ext{item_i.pos_bx[spc_pkg::CoordBits-1]}}, item_i.pos_bx};
  assign by_d = {{Ext{item_i.pos_by[spc_pkg::CoordBits-1]}}, item_i.pos_by};

  always_ff @(posedge clk_i) begin
    if (capture_i) begin
      ax_q  <= ax_d;
      ay_q  <= ay_d;
      bx_q  <= bx_d;
      by_q  <= by_d;
      wa_q  <= $signed(CW'(wa));
      ha_q  <= $signed(CW'(ha));
      wb_q  <= $signed(CW'(wb));
      hb_q  <= $signed(CW'(hb));
      axe_q <= ax_d + $signed(CW'(wa));
      aye_q <= ay_d + $signed(CW'(ha));
      bxe_q <= bx_d + $signed(CW'(wb));
      bye_q <= by_d + $signed(CW'(hb));
    end
  end

  // Touching edges count as meeting, so only strict gaps reject.
  always_comb begin
    reject  = (axe_q < bx_q) || (ax_q > bxe_q) || (aye_q < by_q) || (ay_q > bye_q);
    a_top   = (ay_q >= by_q);
    a_bot   = (aye_q <= bye_q);
    a_left  = (ax_q >= bx_q);
    a_right = (axe_q <= bxe_q);

    if (a_bot) begin
      rows_c = a_top ? ha_q : (aye_q - by_q);
    end else begin
      rows_c = a_top ? (bye_q - ay_q) : hb_q;
    end
    if (a_right) begin
      cols_c = a_left ? wa_q : (axe_q - bx_q);
    end else begin
      cols_c = a_left ? (bxe_q - ax_q) : wb_q;
    end

    plan_d            = '0;
    plan_d.boxes_meet = !reject;
    plan_d.go         = !reject && (rows_c > 0) && (cols_c > 0);
    plan_d.rows       = spc_pkg::RowCntBits'(rows_c);
    plan_d.cols       = spc_pkg::ColBits'(cols_c);
    plan_d.a_row0     = a_top ? '0 : spc_pkg::RowAddrBits'(by_q - ay_q);
    plan_d.b_row0     = a_top ? spc_pkg::RowAddrBits'(ay_q - by_q) : '0;
    plan_d.a_shift    = a_left ? '0 : spc_pkg::ColBits'(bx_q - ax_q);
    plan_d.b_shift    = a_left ? spc_pkg::ColBits'(ax_q - bx_q) : '0;
  end

  always_ff @(posedge clk_i) begin
    plan_q <= plan_d;
  end

  assign plan_o = plan_q;

endmodule

### rtl/sprite_pixel_collision_top.sv
// ----------------------------------------------------------------------------
// Sprite pixel collision
// Pixel-exact collision test between two sprites held as one-bit masks.
// ----------------------------------------------------------------------------
// A load word writes one mask row and returns no result. A test word
// returns one result word and keeps the input closed after acceptance while
// it passes the box, plan, scan, flush and done states; a rejected or empty
// overlap skips the scan and flush states. Each mask memory has one read
// port, so one row of the overlap rectangle (at most MAX_HEIGHT rows) of
// both masks is fetched and compared per cycle during the scan. The result
// word sits in an output register, so the next word is accepted while it
// waits; a test that finishes while the previous result word is still
// waiting holds the input closed until that word is taken. Rows that were
// never loaded give undefined hit values.
module sprite_pixel_collision_top #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  spc_pkg::in_t                     in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output spc_pkg::out_t                    out_data_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spc_pkg::CfgIdxBits-1:0]   cfg_index_i,
  input  logic [spc_pkg::SizeBits-1:0]     cfg_data_i
);

  localparam int unsigned AddrBits = $clog2(MAX_HEIGHT);

  spc_pkg::state_e  state_q, state_d;
  spc_pkg::sizes_t  sizes_q;
  spc_pkg::plan_t   plan;
  spc_pkg::out_t    out_data_q, out_data_d;

  logic                           in_acc, row_ok, is_test;
  logic                           wr_a, wr_b, rd_en;
  logic [AddrBits-1:0]            wr_addr, rd_addr_a, rd_addr_b;
  logic [MAX_WIDTH-1:0]           rd_a, rd_b, a_al, b_al, col_mask;
  logic                           row_hit;
  logic [spc_pkg::RowCntBits-1:0] cnt_q, cnt_d;
  logic                           hit_q, hit_d, rd_valid_q, out_valid_q, out_valid_d;
  logic                           capture, last_row;

  assign in_ready_o  = (state_q == spc_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign is_test     = (in_data_i.op == spc_pkg::OP_TEST);
  assign capture     = in_acc && is_test;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sizes_q <= '{default: spc_pkg::SizeBits'(64)};
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        spc_pkg::REG_WIDTH_A:  sizes_q.width_a  <= cfg_data_i;
        spc_pkg::REG_HEIGHT_A: sizes_q.height_a <= cfg_data_i;
        spc_pkg::REG_WIDTH_B:  sizes_q.width_b  <= cfg_data_i;
        spc_pkg::REG_HEIGHT_B: sizes_q.height_b <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Loads are taken only while no test is in flight, so a scan never reads a
  // row that is being written in the same cycle.
  assign row_ok  = (9'(in_data_i.row_index) < 9'(MAX_HEIGHT));
  assign wr_a    = in_acc && row_ok && (in_data_i.op == spc_pkg::OP_LOAD_A);
  assign wr_b    = in_acc && row_ok && (in_data_i.op == spc_pkg::OP_LOAD_B);
  assign wr_addr = AddrBits'(in_data_i.row_index);

  assign rd_en     = (state_q == spc_pkg::ST_SCAN);
  assign rd_addr_a = plan.a_row0[AddrBits-1:0] + cnt_q[AddrBits-1:0];
  assign rd_addr_b = plan.b_row0[AddrBits-1:0] + cnt_q[AddrBits-1:0];

  spc_mask_mem #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_mask_a (
    .clk_i    (clk_i),
    .wr_en_i  (wr_a),
    .wr_addr_i(wr_addr),
    .wr_data_i(in_data_i.row_bits[MAX_WIDTH-1:0]),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr_a),
    .rd_data_o(rd_a)
  );

  spc_mask_mem #(
    .WIDTH(MAX_WIDTH),
    .DEPTH(MAX_HEIGHT)
  ) u_mask_b (
    .clk_i    (clk_i),
    .wr_en_i  (wr_b),
    .wr_addr_i(wr_addr),
    .wr_data_i(in_data_i.row_bits[MAX_WIDTH-1:0]),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr_b),
    .rd_data_o(rd_b)
  );

  spc_box #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_box (
    .clk_i    (clk_i),
    .capture_i(capture),
    .item_i   (in_data_i),
    .sizes_i  (sizes_q),
    .plan_o   (plan)
  );

  // Line both rows up on the left edge of the overlap and keep only its columns.
  always_comb begin
    a_al = rd_a >> plan.a_shift;
    b_al = rd_b >> plan.b_shift;
    for (int k = 0; k < MAX_WIDTH; k++) begin
      col_mask[k] = (spc_pkg::ColBits'(k) < plan.cols);
    end
    row_hit = |(a_al & b_al & col_mask);
  end

  assign last_row = (spc_pkg::RowCntBits'(cnt_q + 1'b1) == plan.rows);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    hit_d       = hit_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (rd_valid_q && row_hit) begin
      hit_d = 1'b1;
    end

    unique case (state_q)
      spc_pkg::ST_IDLE: begin
        if (capture) begin
          state_d = spc_pkg::ST_BOX;
        end
      end
      spc_pkg::ST_BOX: begin
        state_d = spc_pkg::ST_PLAN;
      end
      spc_pkg::ST_PLAN: begin
        cnt_d   = '0;
        hit_d   = 1'b0;
        state_d = plan.go ? spc_pkg::ST_SCAN : spc_pkg::ST_DONE;
      end
      spc_pkg::ST_SCAN: begin
        cnt_d = spc_pkg::RowCntBits'(cnt_q + 1'b1);
        if (last_row) begin
          state_d = spc_pkg::ST_FLUSH;
        end
      end
      spc_pkg::ST_FLUSH: begin
        state_d = spc_pkg::ST_DONE;
      end
      spc_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d           = 1'b1;
          out_data_d.hit        = hit_q;
          out_data_d.boxes_meet = plan.boxes_meet;
          state_d               = spc_pkg::ST_IDLE;
        end
      end
      default: state_d = spc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spc_pkg::ST_IDLE;
      cnt_q       <= '0;
      hit_q       <= 1'b0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      hit_q       <= hit_d;
      rd_valid_q  <= rd_en;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### rtl/spc_checker.sv
// ----------------------------------------------------------------------------
// Sprite pixel collision checker
// Port-level assertions for the sprite collision block, bound to its top level.
// ----------------------------------------------------------------------------
module spc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input spc_pkg::in_t                   in_data_i,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input spc_pkg::out_t                  out_data_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // A waiting result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed or dropped while stalled");

  // A hit is only possible inside meeting boxes.
  a_hit_needs_meet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.boxes_meet |-> !out_data_o.hit)
    else $error("hit reported for rejected boxes");

  // A test keeps the input closed while it scans.
  a_test_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.op == spc_pkg::OP_TEST) |=> !in_ready_o)
    else $error("input open right after a test word");

  // A load never produces a result word.
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_data_i.op != spc_pkg::OP_TEST) |=> !$rose(out_valid_o))
    else $error("result word after a load");

endmodule

bind sprite_pixel_collision_top spc_checker u_spc_checker (.*);

### tb/spc_collision_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite collision checker
// Watches the configuration, input and result channels of the sprite collision
// block. It keeps its own copy of the sprite sizes and of both opacity masks,
// computes the expected result of every accepted test word, and compares each
// result word in order against those expectations.
// ----------------------------------------------------------------------------
module spc_collision_checker #(
  parameter int unsigned MAX_WIDTH  = 64,
  parameter int unsigned MAX_HEIGHT = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  spc_pkg::in_t                   in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  spc_pkg::out_t                  out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [spc_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [spc_pkg::SizeBits-1:0]   cfg_data_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    outstanding_o
);
  import spc_pkg::*;

  logic [RowBits-1:0]  mask_a [MAX_HEIGHT];
  logic [RowBits-1:0]  mask_b [MAX_HEIGHT];
  logic [SizeBits-1:0] width_a, height_a, width_b, height_b;
  out_t                expected_results [$];
  int unsigned         mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report_failure(input string msg);
    $display("%0t ns checker: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int clamp_size(input logic [SizeBits-1:0] v, input int unsigned limit);
    return (v > limit) ? int'(limit) : int'(v);
  endfunction

  // Box rejection with touching edges counted as meeting, then a scan of the
  // overlap rectangle for a pixel that is opaque in both masks.
  function automatic out_t predict_collision(input in_t w);
    int   ax, ay, bx, by, wa, ha, wb, hb;
    int   top, bottom, left, right;
    logic rejected, hit;
    out_t r;
    ax = w.pos_ax;
    ay = w.pos_ay;
    bx = w.pos_bx;
    by = w.pos_by;
    wa = clamp_size(width_a, MAX_WIDTH);
    ha = clamp_size(height_a, MAX_HEIGHT);
    wb = clamp_size(width_b, MAX_WIDTH);
    hb = clamp_size(height_b, MAX_HEIGHT);
    rejected = (ax + wa < bx) || (ax > bx + wb) || (ay + ha < by) || (ay > by + hb);
    hit = 1'b0;
    if (!rejected) begin
      top    = (ay >= by) ? ay : by;
      bottom = (ay + ha <= by + hb) ? ay + ha : by + hb;
      left   = (ax >= bx) ? ax : bx;
      right  = (ax + wa <= bx + wb) ? ax + wa : bx + wb;
      for (int i = top; i < bottom && !hit; i++) begin
        for (int j = left; j < right; j++) begin
          if (mask_a[i - ay][j - ax] && mask_b[i - by][j - bx]) begin
            hit = 1'b1;
          end
        end
      end
    end
    r.hit        = hit;
    r.boxes_meet = !rejected;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      width_a  = 7'd64;
      height_a = 7'd64;
      width_b  = 7'd64;
      height_b = 7'd64;
      for (int i = 0; i < MAX_HEIGHT; i++) begin
        mask_a[i] = '0;
        mask_b[i] = '0;
      end
      expected_results.delete();
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          report_failure($sformatf("result word hit=%0b boxes_meet=%0b with none expected",
                                   out_data_i.hit, out_data_i.boxes_meet));
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.hit !== want.hit) begin
            report_failure($sformatf("hit expected %0b got %0b", want.hit, out_data_i.hit));
          end
          if (out_data_i.boxes_meet !== want.boxes_meet) begin
            report_failure($sformatf("boxes_meet expected %0b got %0b",
                                     want.boxes_meet, out_data_i.boxes_meet));
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_WIDTH_A:  width_a  = cfg_data_i;
          REG_HEIGHT_A: height_a = cfg_data_i;
          REG_WIDTH_B:  width_b  = cfg_data_i;
          REG_HEIGHT_B: height_b = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        case (op_e'(in_data_i.op))
          OP_LOAD_A: begin
            if (in_data_i.row_index < MAX_HEIGHT) mask_a[in_data_i.row_index] = in_data_i.row_bits;
          end
          OP_LOAD_B: begin
            if (in_data_i.row_index < MAX_HEIGHT) mask_b[in_data_i.row_index] = in_data_i.row_bits;
          end
          OP_TEST: expected_results.push_back(predict_collision(in_data_i));
          default: ;
        endcase
      end

      outstanding_o <= expected_results.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite collision testbench
// Fills both masks, runs a directed set of box and corner cases, then several
// phases of sprite sizes with mostly near-overlapping random tests mixed with
// mask reloads and ignored words. Both sides idle at random and the result
// side holds off twice for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module tb_top;
  import spc_pkg::*;

  localparam int unsigned MaxWidth  = 64;
  localparam int unsigned MaxHeight = 64;
  localparam int          CoordMin  = -(1 << (CoordBits - 1));
  localparam int          CoordMax  = (1 << (CoordBits - 1)) - 1;
  localparam logic [1:0]  OpUnused  = 2'd3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CfgIdxBits-1:0] cfg_index_i;
  logic [SizeBits-1:0]   cfg_data_i;
  int unsigned           fail_count;
  int unsigned           outstanding;

  // Clamped sizes, used to aim random tests near an overlap.
  int          size_wa = 64, size_ha = 64, size_wb = 64, size_hb = 64;
  int unsigned sent_count = 0;
  bit          steady_send = 1'b0;

  sprite_pixel_collision_top #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  spc_collision_checker #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #6ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic in_t make_word(input logic [1:0] op, input logic [RowIdxBits-1:0] row,
                                    input logic [RowBits-1:0] bits,
                                    input int ax, input int ay, input int bx, input int by);
    in_t w;
    w.op        = op;
    w.row_index = row;
    w.row_bits  = bits;
    w.pos_ax    = CoordBits'(ax);
    w.pos_ay    = CoordBits'(ay);
    w.pos_bx    = CoordBits'(bx);
    w.pos_by    = CoordBits'(by);
    return w;
  endfunction

  // Row density: sparse, a single pixel, dense, or a mix with empty and full rows.
  function automatic logic [RowBits-1:0] draw_row(input int unsigned style);
    logic [RowBits-1:0] r;
    r = {$urandom, $urandom};
    case (style)
      0: r = r & {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      1: r = 64'd1 << $urandom_range(0, 63);
      2: ;
      default: begin
        case ($urandom_range(0, 3))
          0: r = '0;
          1: r = '1;
          default: r = r & {$urandom, $urandom} & {$urandom, $urandom};
        endcase
      end
    endcase
    return r;
  endfunction

  task automatic offer_word(input in_t w);
    int unsigned gap;
    if (sent_count % 40 == 0) steady_send = ($urandom_range(0, 3) == 0);
    gap = steady_send ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sent_count++;
  endtask

  // Picks two positions on one axis whose boxes meet, touch or just miss.
  task automatic near_pair(input int own, input int other, output int p_own, output int p_other);
    int off, lo, hi;
    off = int'($urandom_range(0, own + other + 4)) - (other + 2);
    lo  = (off < 0) ? CoordMin - off : CoordMin;
    hi  = (off > 0) ? CoordMax - off : CoordMax;
    case ($urandom_range(0, 9))
      0: p_own = lo;
      1: p_own = hi;
      default: p_own = lo + int'($urandom_range(0, hi - lo));
    endcase
    p_other = p_own + off;
  endtask

  task automatic offer_random_item(input int unsigned style);
    in_t         w;
    int unsigned pick;
    int          ax, ay, bx, by;
    pick = $urandom_range(0, 99);
    w = make_word(OP_TEST, RowIdxBits'($urandom), {$urandom, $urandom},
                  $urandom, $urandom, $urandom, $urandom);
    if (pick < 20) begin
      w.op       = pick[0] ? OP_LOAD_B : OP_LOAD_A;
      w.row_bits = draw_row(style);
    end else if (pick < 23) begin
      w.op = OpUnused;
    end else if (pick >= 33) begin
      near_pair(size_wa, size_wb, ax, bx);
      near_pair(size_ha, size_hb, ay, by);
      w.pos_ax = CoordBits'(ax);
      w.pos_ay = CoordBits'(ay);
      w.pos_bx = CoordBits'(bx);
      w.pos_by = CoordBits'(by);
    end
    offer_word(w);
  endtask

  task automatic wait_for_idle();
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    // A trailing load or an empty test may still be in flight.
    repeat (MaxHeight + 8) @(posedge clk_i);
  endtask

  task automatic program_sizes(input logic [SizeBits-1:0] wa, input logic [SizeBits-1:0] ha,
                               input logic [SizeBits-1:0] wb, input logic [SizeBits-1:0] hb);
    reg_e                regs [4] = '{REG_WIDTH_A, REG_HEIGHT_A, REG_WIDTH_B, REG_HEIGHT_B};
    logic [SizeBits-1:0] vals [4];
    vals = '{wa, ha, wb, hb};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[k];
      cfg_data_i  <= vals[k];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    size_wa = (wa > MaxWidth) ? MaxWidth : wa;
    size_ha = (ha > MaxHeight) ? MaxHeight : ha;
    size_wb = (wb > MaxWidth) ? MaxWidth : wb;
    size_hb = (hb > MaxHeight) ? MaxHeight : hb;
  endtask

  // Result side: random stalls, calm stretches, and two long hold-offs.
  initial begin
    int unsigned gap;
    int unsigned taken;
    bit          steady;
    out_ready_i <= 1'b0;
    taken  = 0;
    steady = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (taken % 50 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, 6);
      if (taken == 150 || taken == 700) gap = 400;
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      taken++;
    end
  end

  initial begin
    logic [SizeBits-1:0] phase_sizes [6][4];
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_data_i   <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= REG_WIDTH_A;
    cfg_data_i  <= '0;
    phase_sizes = '{'{7'd1, 7'd1, 7'd1, 7'd1},
                    '{7'd0, 7'd7, 7'd5, 7'd0},
                    '{7'd127, 7'd127, 7'd127, 7'd127},
                    '{7'd65, 7'd64, 7'd1, 7'd100},
                    '{7'd0, 7'd0, 7'd0, 7'd0},
                    '{7'd0, 7'd0, 7'd0, 7'd0}};
    for (int k = 0; k < 4; k++) begin
      phase_sizes[4][k] = SizeBits'($urandom_range(1, 64));
      phase_sizes[5][k] = SizeBits'($urandom_range(0, 127));
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every mask row is written before any test can scan it.
    for (int r = 0; r < MaxHeight; r++) begin
      offer_word(make_word(OP_LOAD_A, RowIdxBits'(r), draw_row(0),
                           $urandom, $urandom, $urandom, $urandom));
      offer_word(make_word(OP_LOAD_B, RowIdxBits'(r), draw_row(0),
                           $urandom, $urandom, $urandom, $urandom));
    end

    // Directed cases at the reset size of 64 by 64.
    offer_word(make_word(OP_LOAD_A, 6'd0, '1, CoordMin, CoordMax, CoordMin, CoordMax));
    offer_word(make_word(OP_LOAD_B, 6'd63, '1, CoordMax, CoordMin, CoordMax, CoordMin));
    offer_word(make_word(OP_TEST, 6'd63, '1, 0, 0, 0, 0));
    offer_word(make_word(OP_TEST, 6'd0, '0, 0, 0, 64, 0));
    offer_word(make_word(OP_TEST, 6'd0, '0, 0, 0, 65, 0));
    offer_word(make_word(OP_TEST, 6'd0, '0, 64, 0, 0, 0));
    offer_word(make_word(OP_TEST, 6'd0, '0, 65, 0, 0, 0));
    offer_word(make_word(OP_TEST, 6'd0, '0, 0, 0, 0, 64));
    offer_word(make_word(OP_TEST, 6'd0, '0, 0, 0, 0, 65));
    offer_word(make_word(OP_TEST, 6'd0, '0, 0, 64, 0, 0));
    offer_word(make_word(OP_TEST, 6'd0, '0, 0, 65, 0, 0));
    offer_word(make_word(OP_TEST, 6'd0, '0, 0, 0, -64, -64));
    offer_word(make_word(OP_TEST, 6'd0, '0, CoordMin, CoordMin, CoordMax, CoordMax));
    offer_word(make_word(OP_TEST, 6'd0, '0, CoordMax, CoordMax, CoordMax, CoordMax));
    offer_word(make_word(OP_TEST, 6'd0, '0, CoordMin, CoordMin, CoordMin, CoordMin));
    offer_word(make_word(OP_TEST, 6'd0, '0, 0, 0, 63, 63));
    offer_word(make_word(OP_TEST, 6'd0, '0, -63, -63, 0, 0));
    offer_word(make_word(OpUnused, 6'd63, '1, CoordMax, CoordMin, CoordMax, CoordMin));
    offer_word(make_word(OP_TEST, 6'd0, '0, CoordMax - 63, 0, CoordMax, 0));

    for (int p = 0; p < 6; p++) begin
      in_valid_i <= 1'b0;
      wait_for_idle();
      program_sizes(phase_sizes[p][0], phase_sizes[p][1], phase_sizes[p][2], phase_sizes[p][3]);
      for (int n = 0; n < 195; n++) begin
        offer_random_item(p % 4);
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    for (int k = 0; k < 20000 && outstanding != 0; k++) @(posedge clk_i);
    repeat (MaxHeight + 8) @(posedge clk_i);
    if (outstanding != 0) begin
      $display("checker: %0d expected result words never arrived", outstanding);
    end
    if (fail_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
